// ===== hw/rtl/lzg_pkg.sv =====
// lzg_pkg: shared types and constants for the greedy lz77 match encoder
// no dependencies

package lzg_pkg;

    localparam int WIN_SIZE    = 256;
    localparam int LA_SIZE     = 16;
    localparam int NCELL       = WIN_SIZE - 1;
    localparam int OFF_W       = 8;
    localparam int LEN_W       = 4;
    localparam int FILL_W      = 5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_t;

    typedef struct packed {
        logic             is_match;
        logic [7:0]       literal;
        logic [OFF_W-1:0] match_offset;
        logic [LEN_W-1:0] match_length;
        logic             last_token;
    } token_t;

    typedef struct packed {
        logic push;
        logic load;
        logic step;
        logic clear;
    } cell_ctrl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_LOAD,
        ST_SEARCH,
        ST_EMIT,
        ST_PUSH
    } state_t;

endpackage

// ===== hw/rtl/lzg_cell.sv =====
// lzg_cell: one history position of the match chain
// holds a history byte, its valid bit, a scan byte and a match flag
// depends on lzg_pkg

module lzg_cell
    import lzg_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  logic [7:0] hist_in,
    input  logic       vld_in,
    input  logic [7:0] scan_in,
    input  logic [7:0] cmp_byte,
    input  logic       can_match,
    input  logic       in_range,
    output logic [7:0] hist_out,
    output logic       vld_out,
    output logic [7:0] scan_out,
    output logic       hit
);

    logic [7:0] hist_reg;
    logic [7:0] scan_reg;
    logic       vld_reg;
    logic       alive_reg;

    assign hit      = alive_reg && in_range && (scan_reg == cmp_byte);
    assign hist_out = hist_reg;
    assign vld_out  = vld_reg;
    assign scan_out = scan_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.push)
        begin
            hist_reg <= hist_in;
        end
        if (ctrl.load)
        begin
            scan_reg <= hist_reg;
        end
        else if (ctrl.step)
        begin
            scan_reg <= scan_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= 1'b0;
            alive_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.clear)
            begin
                vld_reg <= 1'b0;
            end
            else if (ctrl.push)
            begin
                vld_reg <= vld_in;
            end
            if (ctrl.load)
            begin
                alive_reg <= vld_reg && can_match;
            end
            else if (ctrl.step)
            begin
                alive_reg <= hit;
            end
        end
    end

endmodule

// ===== hw/rtl/lz77_greedy_match_encoder.sv =====
// lz77_greedy_match_encoder: byte in, lz77 token out, greedy longest match
// a chain of lzg_cell holds the history window; control and lookahead here
// depends on lzg_pkg and lzg_cell
//
//   channel   signals                              payload
//   byte      byte_valid / byte_ready / byte_data  byte_t (data_byte, last_byte)
//   token     token_valid / token_ready / token_data token_t
//
// a byte that causes no token is taken in ST_IDLE, checked in ST_CHECK, and the block returns to ST_IDLE
// a byte that causes a token goes through ST_CHECK, ST_LOAD, s search steps (1 to 15,
// one lookahead byte compared against all cells per step), ST_EMIT, n pushes to the chain
// reset clears the control state and the history valid bits
// a held token stalls the block only when the next token is ready to leave

module lz77_greedy_match_encoder
    import lzg_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   byte_valid,
    output logic   byte_ready,
    input  byte_t  byte_data,
    output logic   token_valid,
    input  logic   token_ready,
    output token_t token_data
);

    state_t            state_reg, state_next;
    logic [7:0]        la_reg [LA_SIZE];
    logic [FILL_W-1:0] fill_reg;
    logic              flush_reg;
    logic [LEN_W-1:0]  k_reg;
    logic [LEN_W-1:0]  best_len_reg;
    logic [OFF_W-1:0]  best_d_reg;
    logic [LEN_W-1:0]  cnt_reg;
    token_t            tok_reg;
    logic              tok_valid_reg;

    cell_ctrl_t        ctrl;
    logic [7:0]        hist_w [NCELL+1];
    logic              vld_w  [NCELL+1];
    logic [7:0]        scan_w [NCELL+1];
    logic [NCELL:1]    hit;
    logic              any_hit;
    logic [OFF_W-1:0]  hi_idx;
    logic              gate;
    logic [7:0]        cmp_byte;
    logic              accept;
    logic              emit_go;
    logic              last_pop;
    logic [LEN_W-1:0]  n_bytes;

    assign accept   = byte_valid && byte_ready;
    assign gate     = ({1'b0, k_reg} < fill_reg);
    assign cmp_byte = la_reg[k_reg];
    assign any_hit  = |hit;
    assign emit_go  = !tok_valid_reg || token_ready;
    assign last_pop = (state_reg == ST_PUSH) && (cnt_reg == LEN_W'(1));
    assign n_bytes  = (best_len_reg >= LEN_W'(2)) ? best_len_reg : LEN_W'(1);

    assign hist_w[0] = la_reg[0];
    assign vld_w[0]  = 1'b1;
    assign scan_w[0] = '0;

    genvar gi;
    generate
        for (gi = 1; gi <= NCELL; gi++)
        begin : g_cell
            logic in_range;
            assign in_range = gate && (9'(k_reg) < 9'(gi));
            lzg_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (ctrl),
                .hist_in   (hist_w[gi-1]),
                .vld_in    (vld_w[gi-1]),
                .scan_in   (scan_w[gi-1]),
                .cmp_byte  (cmp_byte),
                .can_match (1'(gi >= 2)),
                .in_range  (in_range),
                .hist_out  (hist_w[gi]),
                .vld_out   (vld_w[gi]),
                .scan_out  (scan_w[gi]),
                .hit       (hit[gi])
            );
        end
    endgenerate

    // highest matching offset wins a tie
    always_comb
    begin
        hi_idx = '0;
        for (int i = 1; i <= NCELL; i++)
        begin
            if (hit[i])
            begin
                hi_idx = OFF_W'(i);
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (byte_valid)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (flush_reg || (fill_reg >= FILL_W'(LA_SIZE - 1)))
                begin
                    state_next = ST_LOAD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (!any_hit || (k_reg == LEN_W'(LA_SIZE - 2)))
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_go)
                begin
                    state_next = ST_PUSH;
                end
            end
            ST_PUSH:
            begin
                if (cnt_reg == LEN_W'(1))
                begin
                    if (flush_reg && (fill_reg != FILL_W'(1)))
                    begin
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        byte_ready = 1'b0;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:   byte_ready = 1'b1;
            ST_LOAD:   ctrl.load  = 1'b1;
            ST_SEARCH: ctrl.step  = 1'b1;
            ST_PUSH:
            begin
                ctrl.push  = 1'b1;
                ctrl.clear = flush_reg && (cnt_reg == LEN_W'(1)) && (fill_reg == FILL_W'(1));
            end
            default:
            begin
                byte_ready = 1'b0;
            end
        endcase
    end

    assign token_valid = tok_valid_reg;
    assign token_data  = tok_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            flush_reg     <= 1'b0;
            k_reg         <= '0;
            best_len_reg  <= '0;
            cnt_reg       <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if ((state_reg == ST_EMIT) && emit_go)
            begin
                tok_valid_reg <= 1'b1;
            end
            else if (tok_valid_reg && token_ready)
            begin
                tok_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        flush_reg <= byte_data.last_byte;
                        if (fill_reg < FILL_W'(LA_SIZE))
                        begin
                            fill_reg <= fill_reg + FILL_W'(1);
                        end
                    end
                end
                ST_LOAD:
                begin
                    k_reg        <= '0;
                    best_len_reg <= '0;
                end
                ST_SEARCH:
                begin
                    k_reg <= k_reg + LEN_W'(1);
                    if (any_hit && (k_reg != '0))
                    begin
                        best_len_reg <= k_reg + LEN_W'(1);
                    end
                end
                ST_EMIT:
                begin
                    if (emit_go)
                    begin
                        cnt_reg <= n_bytes;
                    end
                end
                ST_PUSH:
                begin
                    fill_reg <= fill_reg - FILL_W'(1);
                    cnt_reg  <= cnt_reg - LEN_W'(1);
                    if (ctrl.clear)
                    begin
                        flush_reg <= 1'b0;
                    end
                end
                default:
                begin
                    k_reg <= k_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && (fill_reg < FILL_W'(LA_SIZE)))
        begin
            la_reg[fill_reg[LEN_W-1:0]] <= byte_data.data_byte;
        end
        if (state_reg == ST_PUSH)
        begin
            for (int i = 0; i < LA_SIZE - 1; i++)
            begin
                la_reg[i] <= la_reg[i+1];
            end
        end
        if ((state_reg == ST_SEARCH) && any_hit && (k_reg != '0))
        begin
            best_d_reg <= hi_idx;
        end
        if ((state_reg == ST_EMIT) && emit_go)
        begin
            tok_reg.last_token <= flush_reg && (fill_reg == FILL_W'(n_bytes));
            if (best_len_reg >= LEN_W'(2))
            begin
                tok_reg.is_match     <= 1'b1;
                tok_reg.literal      <= '0;
                tok_reg.match_offset <= best_d_reg;
                tok_reg.match_length <= best_len_reg;
            end
            else
            begin
                tok_reg.is_match     <= 1'b0;
                tok_reg.literal      <= la_reg[0];
                tok_reg.match_offset <= '0;
                tok_reg.match_length <= '0;
            end
        end
    end

    a_idle_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (fill_reg < FILL_W'(LA_SIZE - 1)))
        else $error("lookahead too full while waiting for a byte");

    a_flush_end: assert property (@(posedge clk) disable iff (!rst_n)
        (last_pop && flush_reg && (fill_reg == FILL_W'(1)))
        |=> ((fill_reg == '0) && !flush_reg && (state_reg == ST_IDLE)))
        else $error("block end did not empty the lookahead");

    a_match_len: assert property (@(posedge clk) disable iff (!rst_n)
        (tok_valid_reg && tok_reg.is_match)
        |-> ((tok_reg.match_length >= LEN_W'(2))
            && ({4'b0, tok_reg.match_length} <= tok_reg.match_offset)))
        else $error("match token with bad length");

endmodule

// ===== bench/tb_lz77_greedy_match_encoder.sv =====
// tb_lz77_greedy_match_encoder: random and directed test of the lz77 token encoder
// predicts tokens per byte with a behavioral model, checks each token transfer in order
// depends on lzg_pkg and lz77_greedy_match_encoder
`timescale 1ns / 1ps

module tb_lz77_greedy_match_encoder;
    import lzg_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic   clk;
    logic   rst_n;
    logic   byte_valid;
    logic   byte_ready;
    byte_t  byte_data;
    logic   token_valid;
    logic   token_ready;
    token_t token_data;

    byte_t  pending_bytes[$];
    token_t expected_tokens[$];

    logic [7:0] hist_mem[WIN_SIZE];
    int         hist_count;
    int         hist_wr;
    logic [7:0] la_mem[LA_SIZE];
    int         la_count;

    int  mismatches;
    int  idle_cycles;
    int  send_wait;
    int  recv_wait;

    lz77_greedy_match_encoder dut (
        .clk(clk),
        .rst_n(rst_n),
        .byte_valid(byte_valid),
        .byte_ready(byte_ready),
        .byte_data(byte_data),
        .token_valid(token_valid),
        .token_ready(token_ready),
        .token_data(token_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic logic [7:0] hist_byte(int d, int k);
        return hist_mem[(hist_wr + WIN_SIZE - d + k) % WIN_SIZE];
    endfunction

    task automatic code_one_token(output token_t tok);
        int maxd;
        int lim;
        int len;
        int best_len;
        int best_d;
        int n;
        best_len = 0;
        best_d = 0;
        maxd = (hist_count > WIN_SIZE - 1) ? WIN_SIZE - 1 : hist_count;
        for (int d = maxd; d >= 2; d--)
        begin
            lim = d;
            if (lim > LA_SIZE - 1)
                lim = LA_SIZE - 1;
            if (lim > la_count)
                lim = la_count;
            len = 0;
            while (len < lim && hist_byte(d, len) == la_mem[len])
                len++;
            if (len >= 2 && len > best_len)
            begin
                best_len = len;
                best_d = d;
            end
        end
        tok = '0;
        if (best_len >= 2)
        begin
            tok.is_match = 1'b1;
            tok.match_offset = best_d[OFF_W-1:0];
            tok.match_length = best_len[LEN_W-1:0];
            n = best_len;
        end
        else
        begin
            tok.literal = la_mem[0];
            n = 1;
        end
        for (int k = 0; k < n; k++)
        begin
            hist_mem[hist_wr] = la_mem[k];
            hist_wr = (hist_wr + 1) % WIN_SIZE;
            if (hist_count < WIN_SIZE)
                hist_count++;
        end
        for (int k = 0; k < LA_SIZE - n; k++)
            la_mem[k] = la_mem[k + n];
        la_count -= n;
    endtask

    task automatic predict_tokens(byte_t b);
        token_t tok;
        if (la_count < LA_SIZE)
        begin
            la_mem[la_count] = b.data_byte;
            la_count++;
        end
        if (!b.last_byte)
        begin
            if (la_count >= LA_SIZE - 1)
            begin
                code_one_token(tok);
                expected_tokens.push_back(tok);
            end
        end
        else
        begin
            while (la_count > 0)
            begin
                code_one_token(tok);
                if (la_count == 0)
                    tok.last_token = 1'b1;
                expected_tokens.push_back(tok);
            end
            hist_count = 0;
            hist_wr = 0;
            la_count = 0;
        end
    endtask

    task automatic report_mismatch(string what, token_t got, token_t want);
        $display("error at %0t: %s got %h expected %h", $realtime, what, got, want);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data <= '0;
            send_wait <= 0;
        end
        else if (byte_valid && !byte_ready)
        begin
        end
        else if (send_wait > 0)
        begin
            byte_valid <= 1'b0;
            send_wait <= send_wait - 1;
        end
        else if (pending_bytes.size() > 0)
        begin
            if (byte_valid)
            begin
                byte_valid <= 1'b0;
                send_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            end
            else
            begin
                byte_data <= pending_bytes[0];
                predict_tokens(pending_bytes.pop_front());
                byte_valid <= 1'b1;
            end
        end
        else
            byte_valid <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_ready <= 1'b0;
            recv_wait <= 0;
        end
        else
        begin
            if (token_valid && token_ready)
            begin
                if (expected_tokens.size() == 0)
                    report_mismatch("unexpected token", token_data, '0);
                else if (token_data != expected_tokens[0])
                    report_mismatch("token", token_data, expected_tokens.pop_front());
                else
                    void'(expected_tokens.pop_front());
            end
            if (recv_wait > 0)
            begin
                token_ready <= 1'b0;
                recv_wait <= recv_wait - 1;
            end
            else if (token_valid && token_ready)
            begin
                token_ready <= 1'b0;
                recv_wait <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 19) : 0;
            end
            else
                token_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid && byte_ready) || (token_valid && token_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic queue_block(int len, int alphabet, int bias);
        byte_t b;
        logic [7:0] prev;
        prev = 8'h00;
        for (int i = 0; i < len; i++)
        begin
            b.data_byte = (alphabet >= 256) ? 8'($urandom_range(0, 255))
                                            : 8'($urandom_range(0, alphabet - 1) + bias);
            if ($urandom_range(0, 4) == 0)
                b.data_byte = prev;
            prev = b.data_byte;
            b.last_byte = (i == len - 1);
            pending_bytes.push_back(b);
        end
    endtask

    initial
    begin
        byte_t b;
        mismatches = 0;
        hist_count = 0;
        hist_wr = 0;
        la_count = 0;
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // single byte block, extreme values
        b.data_byte = 8'hff;
        b.last_byte = 1'b1;
        pending_bytes.push_back(b);
        // long run of one value: longest match capped at offset
        for (int i = 0; i < 20; i++)
        begin
            b.data_byte = 8'h00;
            b.last_byte = (i == 19);
            pending_bytes.push_back(b);
        end
        queue_block(3, 256, 0);

        // random blocks; small alphabets give matches, one longer block
        for (int blk = 0; blk < 8; blk++)
            queue_block($urandom_range(1, 16), $urandom_range(1, 4) * 2, 8'($urandom_range(0, 250)));
        queue_block(100, 3, 8'hfd);
        queue_block(10, 256, 0);

        wait (pending_bytes.size() == 0 && !byte_valid);
        wait (expected_tokens.size() == 0);
        repeat (100) @(posedge clk);
        if (mismatches == 0 && expected_tokens.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    always @(posedge clk)
    begin
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
hw/rtl/lzg_pkg.sv
hw/rtl/lzg_cell.sv
hw/rtl/lz77_greedy_match_encoder.sv
bench/tb_lz77_greedy_match_encoder.sv
